[hw/rtl/lfe_pkg.sv]
// Shared types, constants and helpers for the LED fade engine.
package lfe_pkg;

  localparam int CHANNELS = 5;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_FADE   = 2'd1,
    OP_ADJUST = 2'd2,
    OP_HOLD   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EXEC,
    S_CYCGO,
    S_CYC,
    S_DA,
    S_DB,
    S_DC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       running;
    logic [7:0] count;
    logic [7:0] delay;
    logic [7:0] step;
    logic [7:0] target;
    logic [7:0] current;
  } ent_t;

  localparam ent_t ENT_RESET = '{running: 1'b0, count: 8'd0, delay: 8'd1,
                                 step: 8'd1, target: 8'd0, current: 8'd0};

  function automatic logic [7:0] dist8(input logic [7:0] a, input logic [7:0] b);
    dist8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] at_least1(input logic [7:0] v);
    at_least1 = (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

[hw/rtl/lfe_div.sv]
// Shared 8-bit restoring divider, one quotient bit per cycle.
module lfe_div
  import lfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic       done,
  output logic [7:0] q
);

  logic       busy;
  logic [3:0] cnt;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] dvs;
  logic [8:0] shifted;
  logic [8:0] diff;

  assign shifted = {rem, quo[7]};
  assign diff    = shifted - {1'b0, dvs};
  assign q       = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 4'd8;
    end else begin
      done <= busy && (cnt == 4'd1);
      if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 8'd0;
      quo <= a;
      dvs <= b;
    end else if (busy) begin
      if (!diff[8]) begin
        rem <= diff[7:0];
        quo <= {quo[6:0], 1'b1};
      end else begin
        rem <= shifted[7:0];
        quo <= {quo[6:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/lfe_chan.sv]
// Per-channel timer countdown, level step and timer restart.
module lfe_chan
  import lfe_pkg::*;
(
  input  ent_t ent_in,
  input  logic tick,
  input  logic clr,
  output ent_t ent_out
);

  ent_t       e;
  logic [7:0] d;
  logic [7:0] mv;

  always_comb begin
    e  = ent_in;
    d  = dist8(ent_in.current, ent_in.target);
    mv = (d >= ent_in.step) ? ent_in.step : d;
    if (tick && ent_in.running) begin
      if (ent_in.count <= 8'd1) begin
        e.count   = 8'd0;
        e.running = 1'b0;
        if (ent_in.current < ent_in.target) begin
          e.current = ent_in.current + mv;
        end else if (ent_in.current > ent_in.target) begin
          e.current = ent_in.current - mv;
        end
      end else begin
        e.count = ent_in.count - 8'd1;
      end
    end
    if (clr) e.running = 1'b0;
    if (!e.running && (e.current != e.target) && (e.delay != 8'd0)) begin
      e.count   = e.delay;
      e.running = 1'b1;
    end
    ent_out = e;
  end

endmodule

[hw/rtl/multichannel_led_fade_engine.sv]
// Tick and hold update each channel once; fade and adjust first scan every channel,
// then run one division and three more per non-widest channel on the one shared divider.
// Throughput: one request at a time; a finished result waits in the output register.
// Channel state lives in one synchronous RAM, one entry read and written per channel step.
// Reset clears control state; per-entry valid bits make unwritten entries read as
// level 0, target 0, step 1, delay 1, timer stopped.
module multichannel_led_fade_engine
  import lfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic [1:0]       operation,
  input  logic signed [8:0] level_0,
  input  logic signed [8:0] level_1,
  input  logic signed [8:0] level_2,
  input  logic signed [8:0] level_3,
  input  logic signed [8:0] level_4,
  input  logic [7:0]       step_size,
  input  logic [7:0]       delay_ticks,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [7:0]       now_0,
  output logic [7:0]       now_1,
  output logic [7:0]       now_2,
  output logic [7:0]       now_3,
  output logic [7:0]       now_4,
  output logic             all_reached
);

  state_t state, state_next;

  op_t              op;
  logic signed [8:0] lvl [CHANNELS];
  logic [7:0]       step_r;
  logic [7:0]       delay_r;
  logic [CH_W-1:0]  idx;
  logic             pass2;
  logic [CH_W-1:0]  widest;
  logic [7:0]       maxdist;
  logic [7:0]       cycles;
  logic [7:0]       mystep;
  logic [7:0]       now_q [CHANNELS];
  logic             reached;
  logic [7:0]       res_now [CHANNELS];
  logic             res_reached;

  ent_t             mem [CHANNELS];
  ent_t             rdata;
  logic             rd_ok;
  logic [CHANNELS-1:0] valid;
  ent_t             ent;

  logic             accept;
  logic             derive;
  logic             last;
  logic             slot_free;
  logic             mem_re;
  logic             mem_we;
  logic             fin;
  ent_t             wdata;
  ent_t             p1ent;
  ent_t             cin;
  ent_t             cout;
  logic             ctick;
  logic             cclr;
  logic [7:0]       newtgt;
  logic [7:0]       newdist;
  logic [7:0]       d;
  logic [9:0]       sum;
  logic [15:0]      prod;
  logic [7:0]       mydelay;

  logic             div_start;
  logic [7:0]       div_a;
  logic [7:0]       div_b;
  logic             div_done;
  logic [7:0]       div_q;

  lfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  lfe_chan u_chan (
    .ent_in  (cin),
    .tick    (ctick),
    .clr     (cclr),
    .ent_out (cout)
  );

  assign cmd_stall   = (state != S_IDLE);
  assign accept      = cmd_valid && !cmd_stall;
  assign derive      = (op == OP_FADE) || (op == OP_ADJUST);
  assign last        = (idx == CH_W'(CHANNELS - 1));
  assign slot_free   = !res_valid || !res_stall;
  assign ent         = rd_ok ? rdata : ENT_RESET;
  assign d           = dist8(ent.current, ent.target);
  assign prod        = 16'(div_q) * 16'(delay_r);
  assign mydelay     = at_least1(prod[7:0]);

  assign now_0       = res_now[0];
  assign now_1       = res_now[1];
  assign now_2       = res_now[2];
  assign now_3       = res_now[3];
  assign now_4       = res_now[4];
  assign all_reached = res_reached;

  // new target for the first pass of fade and adjust
  always_comb begin
    sum = {2'b00, ent.target} + {lvl[idx][8], lvl[idx]};
    if (op == OP_FADE) begin
      newtgt = lvl[idx][8] ? 8'd0 : lvl[idx][7:0];
    end else if (sum[9]) begin
      newtgt = 8'd0;
    end else if (sum[8]) begin
      newtgt = 8'd255;
    end else begin
      newtgt = sum[7:0];
    end
    newdist      = dist8(ent.current, newtgt);
    p1ent        = ent;
    p1ent.target = newtgt;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_valid) state_next = S_RD;
      S_RD:    state_next = S_EXEC;
      S_EXEC: begin
        if (derive && !pass2) begin
          state_next = last ? S_CYCGO : S_RD;
        end else if (derive && (idx != widest)) begin
          state_next = S_DA;
        end else begin
          state_next = last ? S_DONE : S_RD;
        end
      end
      S_CYCGO: state_next = S_CYC;
      S_CYC:   if (div_done) state_next = S_RD;
      S_DA:    if (div_done) state_next = S_DB;
      S_DB:    if (div_done) state_next = S_DC;
      S_DC:    if (div_done) state_next = last ? S_DONE : S_RD;
      S_DONE:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    fin       = 1'b0;
    div_start = 1'b0;
    div_a     = d;
    div_b     = cycles;
    case (state)
      S_RD: mem_re = 1'b1;
      S_EXEC: begin
        mem_we = 1'b1;
        if (derive && pass2 && (idx != widest)) begin
          mem_we    = 1'b0;
          div_start = 1'b1;
        end else if (!(derive && !pass2)) begin
          fin = 1'b1;
        end
      end
      S_CYCGO: begin
        div_start = 1'b1;
        div_a     = maxdist;
        div_b     = step_r;
      end
      S_DA: begin
        div_start = div_done;
        div_b     = at_least1(div_q);
      end
      S_DB: begin
        div_start = div_done;
        div_a     = cycles;
        div_b     = at_least1(div_q);
      end
      S_DC: begin
        mem_we = div_done;
        fin    = div_done;
      end
      default: ;
    endcase
  end

  // entry fed to the channel update for the last write of each channel
  always_comb begin
    cin   = ent;
    ctick = 1'b0;
    cclr  = 1'b1;
    case (op)
      OP_TICK: begin
        ctick = 1'b1;
        cclr  = 1'b0;
      end
      OP_HOLD: cin.target = ent.current;
      OP_FADE, OP_ADJUST: begin
        if (state == S_EXEC) begin
          cin.step  = step_r;
          cin.delay = delay_r;
        end else begin
          cin.step  = mystep;
          cin.delay = mydelay;
        end
      end
      default: ;
    endcase
    wdata = fin ? cout : p1ent;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= wdata;
    if (mem_re) begin
      rdata <= mem[idx];
      rd_ok <= valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_DONE) && slot_free) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= op_t'(operation);
      lvl[0]  <= level_0;
      lvl[1]  <= level_1;
      lvl[2]  <= level_2;
      lvl[3]  <= level_3;
      lvl[4]  <= level_4;
      step_r  <= at_least1(step_size);
      delay_r <= (op_t'(operation) == OP_FADE) ? at_least1(delay_ticks) : delay_ticks;
      idx     <= '0;
      pass2   <= 1'b0;
      widest  <= '0;
      maxdist <= 8'd0;
      reached <= 1'b1;
    end
    if ((state == S_EXEC) && derive && !pass2 && (newdist > maxdist)) begin
      maxdist <= newdist;
      widest  <= idx;
    end
    if ((state == S_CYC) && div_done) begin
      cycles <= at_least1(div_q);
      pass2  <= 1'b1;
      idx    <= '0;
    end
    if ((state == S_DA) && div_done) mystep <= at_least1(div_q);
    if ((state == S_EXEC) && (state_next == S_RD)) idx <= idx + CH_W'(1);
    if ((state == S_DC) && div_done && !last) idx <= idx + CH_W'(1);
    if (fin) begin
      now_q[idx] <= cout.current;
      if (cout.current != cout.target) reached <= 1'b0;
    end
    if ((state == S_DONE) && slot_free) begin
      res_now     <= now_q;
      res_reached <= reached;
    end
  end

endmodule
